@@ rtl/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to ZYX Euler converter
// Holds the fixed-point widths, the CORDIC arctangent table and the bundle that
// travels from the product/square-root front end to the CORDIC units.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STEPS = 16;

    localparam int Q_W      = 16;   // quaternion part, Q2.14
    localparam int PROD_W   = 32;   // one 16x16 product
    localparam int ARG_W    = 34;   // 2*(a*b +- c*d) and 1 - 2*(...)
    localparam int SQRT_BITS = 29;  // root of a value up to 2^56
    localparam int RAD_W    = 57;   // radicand up to 2^56
    localparam int ATAN_IN_W = 36;  // CORDIC operand input width
    localparam int ZW       = 36;   // angle accumulator, Q.30 radians
    localparam int CW       = 45;   // CORDIC x/y datapath width
    localparam int NORM_MSB = 40;   // operands are scaled until bit 40 leads
    localparam int ANG_W    = 16;   // roll and yaw, Q3.13
    localparam int PITCH_W  = 15;   // pitch, Q2.13

    localparam longint ONE_Q28     = 64'sd268435456;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint PI_Q13      = 64'sd25736;
    localparam longint HALF_PI_Q13 = 64'sd12868;
    localparam longint ROUND_Q30   = 64'sd65536;

    typedef struct packed {
        logic signed [ARG_W-1:0] rn;
        logic signed [ARG_W-1:0] rd;
        logic signed [ARG_W-1:0] yn;
        logic signed [ARG_W-1:0] yd;
        logic signed [ARG_W-1:0] s;
    } args_t;

    typedef struct packed {
        args_t                  args;
        logic                   sat_pos;
        logic                   sat_neg;
        logic [SQRT_BITS-1:0]   root;
    } front_t;

    // atan(2^-i) in Q.30 radians.
    function automatic logic signed [ZW-1:0] atan_q30(input int i);
        logic signed [ZW-1:0] v;
        unique case (i)
            0:  v = ZW'(64'sd843314856);
            1:  v = ZW'(64'sd497837829);
            2:  v = ZW'(64'sd263043836);
            3:  v = ZW'(64'sd133525158);
            4:  v = ZW'(64'sd67021686);
            5:  v = ZW'(64'sd33543515);
            6:  v = ZW'(64'sd16775850);
            7:  v = ZW'(64'sd8388437);
            8:  v = ZW'(64'sd4194282);
            9:  v = ZW'(64'sd2097149);
            10: v = ZW'(64'sd1048575);
            11: v = ZW'(64'sd524287);
            12: v = ZW'(64'sd262143);
            13: v = ZW'(64'sd131071);
            14: v = ZW'(64'sd65535);
            15: v = ZW'(64'sd32767);
            16: v = ZW'(64'sd16383);
            17: v = ZW'(64'sd8191);
            18: v = ZW'(64'sd4095);
            19: v = ZW'(64'sd2047);
            20: v = ZW'(64'sd1023);
            21: v = ZW'(64'sd511);
            22: v = ZW'(64'sd255);
            23: v = ZW'(64'sd127);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/qte_front.sv @@
// ----------------------------------------------------------------------------
// qte_front: product, sum and square-root pipeline
// Forms the five atan2 operands from the quaternion and computes
// isqrt(1 - s^2) for pitch with one root bit per stage.
// ----------------------------------------------------------------------------
module qte_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            vld_in,
    input  logic signed [qte_pkg::Q_W-1:0]  quat_w,
    input  logic signed [qte_pkg::Q_W-1:0]  quat_x,
    input  logic signed [qte_pkg::Q_W-1:0]  quat_y,
    input  logic signed [qte_pkg::Q_W-1:0]  quat_z,
    output logic                            vld_out,
    output qte_pkg::front_t                 front_out
);

    localparam int PW   = qte_pkg::PROD_W;
    localparam int AW   = qte_pkg::ARG_W;
    localparam int NSQ  = qte_pkg::SQRT_BITS;
    localparam int RW   = qte_pkg::RAD_W;
    localparam int NDLY = NSQ + 2;

    typedef struct packed {
        qte_pkg::args_t args;
        logic           sat_pos;
        logic           sat_neg;
    } dly_t;

    logic signed [PW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg;
    logic signed [PW-1:0] xy_reg, zz_reg, wy_reg, zx_reg;
    logic                 v1_reg, v2_reg;
    qte_pkg::args_t       args_reg, args_next;

    dly_t                 dly_reg [NDLY];
    logic                 vld_reg [NDLY];
    logic [2*NSQ-3:0]     ss_reg;
    logic [RW-1:0]        rad_reg;
    logic [RW-1:0]        rem_reg [NSQ];
    logic [NSQ-1:0]       root_reg [NSQ];

    logic signed [NSQ-1:0]   s_trim;
    logic signed [2*NSQ-1:0] s_sq;
    logic                    sat_pos_next, sat_neg_next;

    // Operand sums at 2^-28 resolution.
    always_comb begin
        args_next.rn = (AW'(wx_reg) + AW'(yz_reg)) <<< 1;
        args_next.rd = AW'(qte_pkg::ONE_Q28) - ((AW'(xx_reg) + AW'(yy_reg)) <<< 1);
        args_next.yn = (AW'(wz_reg) + AW'(xy_reg)) <<< 1;
        args_next.yd = AW'(qte_pkg::ONE_Q28) - ((AW'(yy_reg) + AW'(zz_reg)) <<< 1);
        args_next.s  = (AW'(wy_reg) - AW'(zx_reg)) <<< 1;
    end

    // The square is only used when |s| < 1, where s fits in NSQ bits.
    always_comb begin
        s_trim       = $signed(args_reg.s[NSQ-1:0]);
        s_sq         = s_trim * s_trim;
        sat_pos_next = args_reg.s >= AW'(qte_pkg::ONE_Q28);
        sat_neg_next = args_reg.s <= -AW'(qte_pkg::ONE_Q28);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wx_reg   <= quat_w * quat_x;
            yz_reg   <= quat_y * quat_z;
            xx_reg   <= quat_x * quat_x;
            yy_reg   <= quat_y * quat_y;
            wz_reg   <= quat_w * quat_z;
            xy_reg   <= quat_x * quat_y;
            zz_reg   <= quat_z * quat_z;
            wy_reg   <= quat_w * quat_y;
            zx_reg   <= quat_z * quat_x;
            args_reg <= args_next;
            dly_reg[0].args    <= args_reg;
            dly_reg[0].sat_pos <= sat_pos_next;
            dly_reg[0].sat_neg <= sat_neg_next;
            ss_reg   <= s_sq[2*NSQ-3:0];
            dly_reg[1] <= dly_reg[0];
            rad_reg  <= (RW'(1) << (RW - 1)) - RW'(ss_reg);
            for (int i = 2; i < NDLY; i++) begin
                dly_reg[i] <= dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            for (int i = 0; i < NDLY; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v1_reg     <= vld_in;
            v2_reg     <= v1_reg;
            vld_reg[0] <= v2_reg;
            for (int i = 1; i < NDLY; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Restoring square root, most significant root bit first.
    for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
        localparam int K = NSQ - 1 - j;
        logic [RW-1:0]  rem_in;
        logic [NSQ-1:0] root_in;
        logic [RW+1:0]  trial;
        logic [RW+1:0]  rem_wide;

        if (j == 0) begin : g_first
            assign rem_in  = rad_reg;
            assign root_in = '0;
        end else begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        assign trial    = ((RW+2)'(root_in) << (K + 1)) + ((RW+2)'(1) << (2 * K));
        assign rem_wide = (RW+2)'(rem_in);

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_wide >= trial) begin
                    rem_reg[j]  <= RW'(rem_wide - trial);
                    root_reg[j] <= root_in | (NSQ'(1) << K);
                end else begin
                    rem_reg[j]  <= rem_in;
                    root_reg[j] <= root_in;
                end
            end
        end
    end

    assign vld_out           = vld_reg[NDLY-1];
    assign front_out.args    = dly_reg[NDLY-1].args;
    assign front_out.sat_pos = dly_reg[NDLY-1].sat_pos;
    assign front_out.sat_neg = dly_reg[NDLY-1].sat_neg;
    assign front_out.root    = root_reg[NSQ-1];

endmodule

@@ rtl/qte_atan2.sv @@
// ----------------------------------------------------------------------------
// qte_atan2: pipelined vectoring CORDIC for atan2(y, x)
// Quadrant fold, normalization to a fixed leading bit, one CORDIC iteration
// per stage, then rounding of the Q.30 angle to Q3.13 with a clamp to +-pi.
// ----------------------------------------------------------------------------
module qte_atan2 (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  en,
    input  logic                                  vld_in,
    input  logic signed [qte_pkg::ATAN_IN_W-1:0]  y_in,
    input  logic signed [qte_pkg::ATAN_IN_W-1:0]  x_in,
    output logic                                  vld_out,
    output logic signed [qte_pkg::ANG_W-1:0]      angle
);

    localparam int IW = qte_pkg::ATAN_IN_W;
    localparam int FW = IW + 1;
    localparam int MW = IW;
    localparam int CW = qte_pkg::CW;
    localparam int ZW = qte_pkg::ZW;
    localparam int NS = qte_pkg::CORDIC_STEPS;
    localparam int RQ = ZW - 17;

    // Fold stage
    logic signed [FW-1:0] fx_next, fy_next, ax, ay;
    logic signed [ZW-1:0] z0_next;
    logic signed [FW-1:0] fx_reg, fy_reg, fx2_reg, fy2_reg;
    logic signed [ZW-1:0] z0_reg, z02_reg;
    logic [MW-1:0]        m_reg;
    logic                 zero_reg, zero2_reg;
    // Normalize stage
    logic [5:0]           msb, sh_reg;
    // CORDIC stages
    logic signed [CW-1:0] x_reg [NS+1];
    logic signed [CW-1:0] y_reg [NS+1];
    logic signed [ZW-1:0] z_reg [NS+1];
    logic                 zc_reg [NS+1];
    logic                 vld_reg [NS+4];
    // Output stage
    logic signed [ZW-1:0] zr;
    logic signed [RQ-1:0] rq;
    logic signed [qte_pkg::ANG_W-1:0] angle_reg, angle_next;

    always_comb begin
        if (x_in < 0) begin
            if (y_in >= 0) begin
                fx_next = FW'(y_in);
                fy_next = -FW'(x_in);
                z0_next = ZW'(qte_pkg::HALF_PI_Q30);
            end else begin
                fx_next = -FW'(y_in);
                fy_next = FW'(x_in);
                z0_next = -ZW'(qte_pkg::HALF_PI_Q30);
            end
        end else begin
            fx_next = FW'(x_in);
            fy_next = FW'(y_in);
            z0_next = '0;
        end
        ax = fx_next[FW-1] ? -fx_next : fx_next;
        ay = fy_next[FW-1] ? -fy_next : fy_next;
    end

    always_comb begin
        msb = '0;
        for (int b = 0; b < MW; b++) begin
            if (m_reg[b]) begin
                msb = 6'(b);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fx_reg    <= fx_next;
            fy_reg    <= fy_next;
            z0_reg    <= z0_next;
            m_reg     <= (ax > ay) ? MW'(ax) : MW'(ay);
            zero_reg  <= (x_in == 0) && (y_in == 0);
            fx2_reg   <= fx_reg;
            fy2_reg   <= fy_reg;
            z02_reg   <= z0_reg;
            zero2_reg <= zero_reg;
            sh_reg    <= 6'(qte_pkg::NORM_MSB) - msb;
            x_reg[0]  <= CW'(fx2_reg) <<< sh_reg;
            y_reg[0]  <= CW'(fy2_reg) <<< sh_reg;
            z_reg[0]  <= z02_reg;
            zc_reg[0] <= zero2_reg;
            angle_reg <= angle_next;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_iter
        logic signed [CW-1:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge aclk) begin
            if (en) begin
                if (!y_reg[i][CW-1]) begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + qte_pkg::atan_q30(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - qte_pkg::atan_q30(i);
                end
                zc_reg[i+1] <= zc_reg[i];
            end
        end
    end

    always_comb begin
        zr = z_reg[NS] + ZW'(qte_pkg::ROUND_Q30);
        rq = $signed(zr[ZW-1:17]);
        if (zc_reg[NS]) begin
            angle_next = '0;
        end else if (rq > RQ'(qte_pkg::PI_Q13)) begin
            angle_next = qte_pkg::ANG_W'(qte_pkg::PI_Q13);
        end else if (rq < -RQ'(qte_pkg::PI_Q13)) begin
            angle_next = -qte_pkg::ANG_W'(qte_pkg::PI_Q13);
        end else begin
            angle_next = rq[qte_pkg::ANG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NS + 4; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= vld_in;
            for (int i = 1; i < NS + 4; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign vld_out = vld_reg[NS+3];
    assign angle   = angle_reg;

endmodule

@@ rtl/quaternion_to_euler_zyx.sv @@
// Throughput: one quaternion per cycle; every stage advances together and holds
// while a finished result waits on m_tready.
// Depth is set by the 29-stage square-root pipeline and the per-step CORDIC stages.
// Reset (aresetn low, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_zyx: quaternion (Q2.14) to roll and yaw (Q3.13), pitch (Q2.13)
// Product front end feeding three pipelined CORDIC atan2 units.
// ----------------------------------------------------------------------------
module quaternion_to_euler_zyx (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata     // roll[15:0], pitch[30:16], yaw[46:31], zero pad[47]
);

    localparam int IW = qte_pkg::ATAN_IN_W;
    localparam int AW = qte_pkg::ANG_W;
    localparam int PW = qte_pkg::PITCH_W;
    localparam int ND = qte_pkg::CORDIC_STEPS + 4;

    logic                   en;
    logic                   front_vld;
    qte_pkg::front_t        front;
    logic                   roll_vld, yaw_vld, pitch_vld;
    logic signed [AW-1:0]   roll_ang, yaw_ang, pitch_ang;
    logic                   satp_reg [ND];
    logic                   satn_reg [ND];
    logic signed [PW-1:0]   pitch_next;
    logic                   m_tvalid_reg;
    logic [47:0]            m_tdata_reg;

    // The whole pipeline moves unless a result is held at the output.
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    qte_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .vld_in    (s_tvalid),
        .quat_w    ($signed(s_tdata[15:0])),
        .quat_x    ($signed(s_tdata[31:16])),
        .quat_y    ($signed(s_tdata[47:32])),
        .quat_z    ($signed(s_tdata[63:48])),
        .vld_out   (front_vld),
        .front_out (front)
    );

    qte_atan2 u_roll (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (front_vld),
        .y_in    (IW'($signed(front.args.rn))),
        .x_in    (IW'($signed(front.args.rd))),
        .vld_out (roll_vld),
        .angle   (roll_ang)
    );

    qte_atan2 u_yaw (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (front_vld),
        .y_in    (IW'($signed(front.args.yn))),
        .x_in    (IW'($signed(front.args.yd))),
        .vld_out (yaw_vld),
        .angle   (yaw_ang)
    );

    qte_atan2 u_pitch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .vld_in  (front_vld),
        .y_in    (IW'($signed(front.args.s))),
        .x_in    (IW'($signed({1'b0, front.root}))),
        .vld_out (pitch_vld),
        .angle   (pitch_ang)
    );

    // Saturation flags ride alongside the pitch CORDIC.
    always_ff @(posedge aclk) begin
        if (en) begin
            satp_reg[0] <= front.sat_pos;
            satn_reg[0] <= front.sat_neg;
            for (int i = 1; i < ND; i++) begin
                satp_reg[i] <= satp_reg[i-1];
                satn_reg[i] <= satn_reg[i-1];
            end
        end
    end

    always_comb begin
        priority if (satp_reg[ND-1]) begin
            pitch_next = PW'(qte_pkg::HALF_PI_Q13);
        end else if (satn_reg[ND-1]) begin
            pitch_next = -PW'(qte_pkg::HALF_PI_Q13);
        end else if (pitch_ang > AW'(qte_pkg::HALF_PI_Q13)) begin
            pitch_next = PW'(qte_pkg::HALF_PI_Q13);
        end else if (pitch_ang < -AW'(qte_pkg::HALF_PI_Q13)) begin
            pitch_next = -PW'(qte_pkg::HALF_PI_Q13);
        end else begin
            pitch_next = pitch_ang[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= roll_vld && yaw_vld && pitch_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= {1'b0, yaw_ang, pitch_next, roll_ang};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ tb/sv/tb_quaternion_to_euler_zyx.sv @@
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_zyx: regression bench for the quaternion to Euler block
// Drives quaternions in random bursts, stalls the result side on its own
// pattern, and checks each roll, pitch and yaw against an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_zyx;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 200;
    localparam int  RANDOM_ITEMS   = 1600;
    localparam longint NORM_LIMIT  = 64'sd1099511627776;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } quat_t;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } euler_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;    // roll[15:0], pitch[30:16], yaw[46:31], zero pad[47]

    quat_t  pending_quats[$];
    euler_t expected_angles[$];
    int     mismatch_count;
    int     idle_cycles;
    bit     stimulus_done;
    bit     s_taken;
    int     burst_left;
    int     gap_left;
    int     stall_phase;

    quaternion_to_euler_zyx u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Floor division by a power of two, as an arithmetic shift.
    function automatic longint shift_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt_u64(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint atan_table(int i);
        longint tab[24];
        tab = '{843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
                16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
                131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
        return tab[i];
    endfunction

    // Vectoring arctangent, Q3.13 radians, held to +-pi.
    function automatic longint cordic_atan2(longint ny, longint nx);
        longint ang, m, t, dx, dy, r;
        ang = 0;
        if (nx == 0 && ny == 0) return 0;
        if (nx < 0) begin
            if (ny >= 0) begin
                t = nx; nx = ny; ny = -t;
                ang = qte_pkg::HALF_PI_Q30;
            end else begin
                t = nx; nx = -ny; ny = t;
                ang = -qte_pkg::HALF_PI_Q30;
            end
        end
        m = ((nx < 0 ? -nx : nx) > (ny < 0 ? -ny : ny)) ? (nx < 0 ? -nx : nx)
                                                        : (ny < 0 ? -ny : ny);
        while (m < NORM_LIMIT) begin
            nx = nx * 2;
            ny = ny * 2;
            m = m * 2;
        end
        for (int i = 0; i < qte_pkg::CORDIC_STEPS && i < 24; i++) begin
            dx = shift_floor(ny, i);
            dy = shift_floor(nx, i);
            if (ny >= 0) begin
                nx = nx + dx; ny = ny - dy; ang = ang + atan_table(i);
            end else begin
                nx = nx - dx; ny = ny + dy; ang = ang - atan_table(i);
            end
        end
        r = shift_floor(ang + qte_pkg::ROUND_Q30, 17);
        if (r > qte_pkg::PI_Q13) r = qte_pkg::PI_Q13;
        if (r < -qte_pkg::PI_Q13) r = -qte_pkg::PI_Q13;
        return r;
    endfunction

    function automatic euler_t predict_euler(quat_t q);
        longint w, x, y, z, rn, rd, yn, yd, s, p;
        longint unsigned ss;
        euler_t e;
        w = q.w; x = q.x; y = q.y; z = q.z;
        rn = 2 * (w * x + y * z);
        rd = qte_pkg::ONE_Q28 - 2 * (x * x + y * y);
        yn = 2 * (w * z + x * y);
        yd = qte_pkg::ONE_Q28 - 2 * (y * y + z * z);
        s  = 2 * (w * y - z * x);
        if (s >= qte_pkg::ONE_Q28) begin
            p = qte_pkg::HALF_PI_Q13;
        end else if (s <= -qte_pkg::ONE_Q28) begin
            p = -qte_pkg::HALF_PI_Q13;
        end else begin
            ss = longint'(s * s);
            p = cordic_atan2(s, isqrt_u64((64'd1 << 56) - ss));
            if (p > qte_pkg::HALF_PI_Q13) p = qte_pkg::HALF_PI_Q13;
            if (p < -qte_pkg::HALF_PI_Q13) p = -qte_pkg::HALF_PI_Q13;
        end
        e.roll  = 16'(cordic_atan2(rn, rd));
        e.pitch = 15'(p);
        e.yaw   = 16'(cordic_atan2(yn, yd));
        return e;
    endfunction

    function automatic quat_t make_quat(int w, int x, int y, int z);
        quat_t q;
        q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
        return q;
    endfunction

    function automatic logic signed [15:0] rand_part();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // Builds a near-unit quaternion from random parts scaled by their norm.
    function automatic quat_t rand_unit_quat();
        real a, b, c, d, n;
        a = $itor(rand_part()); b = $itor(rand_part());
        c = $itor(rand_part()); d = $itor(rand_part());
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) return make_quat(16384, 0, 0, 0);
        return make_quat($rtoi(a * 16384.0 / n), $rtoi(b * 16384.0 / n),
                         $rtoi(c * 16384.0 / n), $rtoi(d * 16384.0 / n));
    endfunction

    initial begin
        int k;
        pending_quats.push_back(make_quat(16384, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 16384, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 16384, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 16384));
        pending_quats.push_back(make_quat(-16384, -16384, -16384, -16384));
        pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
        pending_quats.push_back(make_quat(11585, 0, 11585, 0));     // gimbal lock, positive
        pending_quats.push_back(make_quat(11585, 0, -11585, 0));    // gimbal lock, negative
        pending_quats.push_back(make_quat(11586, 0, 11586, 0));
        pending_quats.push_back(make_quat(0, 11585, 0, 11585));
        pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
        pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
        pending_quats.push_back(make_quat(32767, -32768, 32767, -32768));
        pending_quats.push_back(make_quat(-1, -1, -1, -1));
        pending_quats.push_back(make_quat(1, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 1, 0));
        pending_quats.push_back(make_quat(0, 12000, 12000, 0));     // atan2 on the negative x axis
        pending_quats.push_back(make_quat(8192, 8192, 8192, 8192));
        pending_quats.push_back(make_quat(-8192, 8192, -8192, 8192));
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            case ($urandom_range(9))
                0:       pending_quats.push_back(quat_t'({$urandom, $urandom}));
                1, 2:    pending_quats.push_back(make_quat(rand_part(), rand_part(),
                                                           rand_part(), rand_part()));
                default: pending_quats.push_back(rand_unit_quat());
            endcase
        end
        stimulus_done = 1'b1;
    end

    initial begin
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    // Sender: bursts of random length separated by random gaps.
    // A held item moves on only after the rising edge has taken it.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            burst_left <= $urandom_range(40, 1);
            gap_left <= 0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left > 0 || pending_quats.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_quats[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // Receiver: stall pattern that cycles through open, sparse and heavy phases.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 300) % 3)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(3) != 0);
                default: m_tready <= ($urandom_range(3) == 0);
            endcase
        end
    end

    // Queue pop and prediction happen on the transfer at the rising edge.
    always @(posedge aclk) begin
        euler_t got, want;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_angles.push_back(predict_euler(quat_t'(s_tdata)));
            void'(pending_quats.pop_front());
        end
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[46:0];
            if (expected_angles.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result transfer: %h", m_tdata);
            end else begin
                want = expected_angles.pop_front();
                if (got !== want || m_tdata[47] !== 1'b0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/got)",
                                 want.roll, got.roll, want.pitch, got.pitch,
                                 want.yaw, got.yaw);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        mismatch_count = 0;
        idle_cycles = 0;
    end

    initial begin
        @(posedge aresetn);
        while (!(stimulus_done && pending_quats.size() == 0 && !s_tvalid
                 && expected_angles.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("quaternion_to_euler_zyx regression: fail");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge aclk);
            if (mismatch_count == 0 && expected_angles.size() == 0)
                $display("quaternion_to_euler_zyx regression: pass");
            else
                $display("quaternion_to_euler_zyx regression: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/qte_pkg.sv
rtl/qte_front.sv
rtl/qte_atan2.sv
rtl/quaternion_to_euler_zyx.sv
tb/sv/tb_quaternion_to_euler_zyx.sv
